// ===== hw/rtl/nrt_pkg.sv =====
`default_nettype none

package nrt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CH_W        = 5;
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;

  typedef logic [TABLE_DEPTH-1:0] row_mask_t;
  typedef logic [IDX_W-1:0]       row_idx_t;
  typedef logic [CH_W-1:0]        chan_t;
  typedef logic [NOTE_W-1:0]      note_t;
  typedef logic [VEL_W-1:0]       vel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } nrt_state_t;

  typedef struct packed {
    logic capture;
    logic remove_mapped;
    logic release_orig;
    logic insert;
    logic load_on;
    logic emit;
  } nrt_cmd_t;

  typedef struct packed {
    logic is_pending_off;
    logic is_note_off;
    logic table_full;
    logic any_match;
    logic out_enable;
    logic slot_free;
    logic last_emit;
  } nrt_sts_t;

  // Lowest set bit of a row mask; zero when the mask is empty.
  function automatic row_idx_t first_set(input row_mask_t m);
    row_idx_t idx;
    idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = row_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nrt_in_if.sv =====
`default_nettype none

interface nrt_in_if;
  import nrt_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  logic  is_note_off;
  chan_t channel;
  note_t note_number;
  note_t original_note;
  vel_t  velocity;

  modport source (
    output valid, func, is_note_off, channel, note_number, original_note, velocity,
    input  ready
  );

  modport sink (
    input  valid, func, is_note_off, channel, note_number, original_note, velocity,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/nrt_out_if.sv =====
`default_nettype none

interface nrt_out_if;
  import nrt_pkg::*;

  logic  valid;
  logic  ready;
  logic  out_note_off;
  chan_t out_channel;
  note_t out_note_number;
  vel_t  out_velocity;
  logic  last;

  modport source (
    output valid, out_note_off, out_channel, out_note_number, out_velocity, last,
    input  ready
  );

  modport sink (
    input  valid, out_note_off, out_channel, out_note_number, out_velocity, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/nrt_ctrl.sv =====
`default_nettype none

module nrt_ctrl
  import nrt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire nrt_sts_t sts,
  output nrt_cmd_t      cmd
);

  nrt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.is_pending_off) begin
          state_nxt = ST_IDLE;
        end else if (sts.is_note_off) begin
          state_nxt = (sts.out_enable && sts.any_match) ? ST_EMIT : ST_IDLE;
        end else if (sts.table_full || !sts.out_enable || sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free && sts.last_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        if (sts.is_pending_off) begin
          cmd.remove_mapped = 1'b1;
        end else if (sts.is_note_off) begin
          cmd.release_orig = 1'b1;
        end else if (!sts.table_full) begin
          // hold the note-on until the output register can take it
          if (!sts.out_enable) begin
            cmd.insert = 1'b1;
          end else if (sts.slot_free) begin
            cmd.insert  = 1'b1;
            cmd.load_on = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        cmd.emit = sts.slot_free;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nrt_datapath.sv =====
`default_nettype none

module nrt_datapath
  import nrt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire logic     in_func,
  input  wire logic     in_is_note_off,
  input  wire chan_t    in_channel,
  input  wire note_t    in_note_number,
  input  wire note_t    in_original_note,
  input  wire vel_t     in_velocity,
  input  wire nrt_cmd_t cmd,
  output nrt_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic          out_note_off,
  output chan_t         out_channel,
  output note_t         out_note_number,
  output vel_t          out_velocity,
  output logic          out_last
);

  logic      out_en_r;

  logic      itm_func_r;
  logic      itm_off_r;
  chan_t     itm_ch_r;
  note_t     itm_note_r;
  note_t     itm_orig_r;
  vel_t      itm_vel_r;

  row_mask_t valid_r;
  chan_t     ent_ch_r   [TABLE_DEPTH];
  note_t     ent_orig_r [TABLE_DEPTH];
  note_t     ent_map_r  [TABLE_DEPTH];

  row_mask_t mask_r;

  logic      out_valid_r;
  logic      out_off_r;
  chan_t     out_ch_r;
  note_t     out_note_r;
  vel_t      out_vel_r;
  logic      out_last_r;

  row_mask_t match_orig;
  row_mask_t match_map;
  row_idx_t  free_idx;
  row_idx_t  emit_idx;
  row_mask_t mask_rest;
  logic      slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      out_en_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      itm_func_r <= in_func;
      itm_off_r  <= in_is_note_off;
      itm_ch_r   <= in_channel;
      itm_note_r <= in_note_number;
      itm_orig_r <= in_original_note;
      itm_vel_r  <= in_velocity;
    end
  end

  // Compare every row against the held item in parallel.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_orig[i] = valid_r[i] && (ent_ch_r[i] == itm_ch_r) && (ent_orig_r[i] == itm_orig_r);
      match_map[i]  = valid_r[i] && (ent_ch_r[i] == itm_ch_r) && (ent_map_r[i] == itm_note_r);
    end
  end

  assign free_idx  = first_set(~valid_r);
  assign emit_idx  = first_set(mask_r);
  assign mask_rest = mask_r & (mask_r - row_mask_t'(1));
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.remove_mapped) begin
      valid_r <= valid_r & ~match_map;
    end else if (cmd.release_orig) begin
      valid_r <= valid_r & ~match_orig;
    end else if (cmd.insert) begin
      valid_r[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      ent_ch_r[free_idx]   <= itm_ch_r;
      ent_orig_r[free_idx] <= itm_orig_r;
      ent_map_r[free_idx]  <= itm_note_r;
    end
  end

  // Rows freed by a note-off, still to be sent lowest first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cmd.release_orig) begin
      mask_r <= match_orig;
    end else if (cmd.emit) begin
      mask_r <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_on || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_on) begin
      out_off_r  <= 1'b0;
      out_ch_r   <= itm_ch_r;
      out_note_r <= itm_note_r;
      out_vel_r  <= itm_vel_r;
      out_last_r <= 1'b1;
    end else if (cmd.emit) begin
      out_off_r  <= 1'b1;
      out_ch_r   <= itm_ch_r;
      out_note_r <= ent_map_r[emit_idx];
      out_vel_r  <= itm_vel_r;
      out_last_r <= (mask_rest == '0);
    end
  end

  always_comb begin
    sts                = '0;
    sts.is_pending_off = itm_func_r;
    sts.is_note_off    = itm_off_r;
    sts.table_full     = &valid_r;
    sts.any_match      = |match_orig;
    sts.out_enable     = out_en_r;
    sts.slot_free      = slot_free;
    sts.last_emit      = (mask_rest == '0);
  end

  assign out_valid       = out_valid_r;
  assign out_note_off    = out_off_r;
  assign out_channel     = out_ch_r;
  assign out_note_number = out_note_r;
  assign out_velocity    = out_vel_r;
  assign out_last        = out_last_r;

  a_emit_has_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (mask_r != '0))
    else $error("emit with no pending row");

  a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !(&valid_r))
    else $error("insert into a full table");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.load_on) |-> slot_free)
    else $error("output register overwritten while stalled");

  a_insert_sets_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> valid_r[$past(free_idx)])
    else $error("inserted row not marked valid");

endmodule

`default_nettype wire

// ===== hw/rtl/note_remap_tracker.sv =====
`default_nettype none

// Tracks up to 32 sounding notes (channel, original note, remapped note) and turns note-offs
// into note-offs for the remapped numbers. A note-on takes the lowest free row and is passed
// through; with the table full it is dropped. A note-off frees every row matching channel and
// original note and sends one note-off per freed row, lowest row first, the final one with last
// set. A pending-off item frees rows matching channel and remapped note and sends nothing. With
// cfg output_enable at 0 the table still updates but no transfers appear on the result channel.
// Timing: an item is evaluated against all rows at once in the cycle after it is accepted.
// The single output register takes one result per cycle while the result side does not
// stall.
// in ready is high only between items; the last result may still wait in the output register
// while the next item is taken.
module note_remap_tracker
  import nrt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  nrt_in_if.sink    in_ch,
  nrt_out_if.source out_ch,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);

  nrt_cmd_t cmd;
  nrt_sts_t sts;

  nrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nrt_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_func          (in_ch.func),
    .in_is_note_off   (in_ch.is_note_off),
    .in_channel       (in_ch.channel),
    .in_note_number   (in_ch.note_number),
    .in_original_note (in_ch.original_note),
    .in_velocity      (in_ch.velocity),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_note_off     (out_ch.out_note_off),
    .out_channel      (out_ch.out_channel),
    .out_note_number  (out_ch.out_note_number),
    .out_velocity     (out_ch.out_velocity),
    .out_last         (out_ch.last)
  );

endmodule

`default_nettype wire

// ===== sim/nrt_tb_pkg.sv =====
`timescale 1ns / 1ps

package nrt_tb_pkg;

  // func field of an input item
  localparam logic FUNC_NOTE        = 1'b0;
  localparam logic FUNC_PENDING_OFF = 1'b1;

  // note-on / note-off flag, on the input and on the result
  localparam logic MSG_NOTE_ON  = 1'b0;
  localparam logic MSG_NOTE_OFF = 1'b1;

endpackage

// ===== sim/note_remap_checker.sv =====
`timescale 1ns / 1ps

module note_remap_checker
  import nrt_pkg::*;
  import nrt_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  nrt_in_if    in_mon,
  nrt_out_if   out_mon,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output int   fail_count,
  output int   outstanding,
  output int   results_seen,
  output int   drops,
  output int   widest_release
);

  localparam int RESULT_CAP   = 32;
  localparam int REPORT_LINES = 25;

  typedef struct packed {
    logic  off;
    chan_t chan;
    note_t note;
    vel_t  vel;
    logic  last;
  } note_msg_t;

  note_msg_t expected_notes[$];
  logic      send_enable;
  logic      held[TABLE_DEPTH];
  chan_t     held_chan[TABLE_DEPTH];
  note_t     held_orig[TABLE_DEPTH];
  note_t     held_mapped[TABLE_DEPTH];

  initial begin
    fail_count     = 0;
    outstanding    = 0;
    results_seen   = 0;
    drops          = 0;
    widest_release = 0;
    send_enable    = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) held[i] = 1'b0;
  end

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= REPORT_LINES) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Update the note table for one accepted item and queue the results it causes.
  task automatic track_event(input logic func, input logic is_off, input chan_t ch,
                             input note_t note, input note_t orig, input vel_t vel);
    note_msg_t msg;
    int        base;
    int        hits;
    int        slot;
    base = expected_notes.size();
    hits = 0;
    slot = -1;
    if (func == FUNC_PENDING_OFF) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (held[i] && held_chan[i] == ch && held_mapped[i] == note) held[i] = 1'b0;
      end
    end else if (is_off == MSG_NOTE_OFF) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (held[i] && held_chan[i] == ch && held_orig[i] == orig) begin
          if (send_enable && hits < RESULT_CAP) begin
            msg.off  = MSG_NOTE_OFF;
            msg.chan = ch;
            msg.note = held_mapped[i];
            msg.vel  = vel;
            msg.last = 1'b0;
            expected_notes.insert(expected_notes.size(), msg);
          end
          hits++;
          held[i] = 1'b0;
        end
      end
      if (hits > widest_release) widest_release = hits;
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!held[i] && slot < 0) slot = i;
      end
      if (slot < 0) begin
        drops++;
      end else begin
        held[slot]        = 1'b1;
        held_chan[slot]   = ch;
        held_orig[slot]   = orig;
        held_mapped[slot] = note;
        if (send_enable) begin
          msg.off  = MSG_NOTE_ON;
          msg.chan = ch;
          msg.note = note;
          msg.vel  = vel;
          msg.last = 1'b0;
          expected_notes.insert(expected_notes.size(), msg);
        end
      end
    end
    // mark the final result of this item
    if (expected_notes.size() > base) begin
      msg = expected_notes.pop_back();
      msg.last = 1'b1;
      expected_notes.insert(expected_notes.size(), msg);
    end
  endtask

  task automatic check_result();
    note_msg_t want;
    if (expected_notes.size() == 0) begin
      report($sformatf("unexpected result off=%0b ch=%0d note=%0d vel=%0d last=%0b",
                       out_mon.out_note_off, out_mon.out_channel, out_mon.out_note_number,
                       out_mon.out_velocity, out_mon.last));
      return;
    end
    want = expected_notes.pop_front();
    results_seen++;
    if (out_mon.out_note_off !== want.off)
      report($sformatf("out_note_off got %0b want %0b", out_mon.out_note_off, want.off));
    if (out_mon.out_channel !== want.chan)
      report($sformatf("out_channel got %0d want %0d", out_mon.out_channel, want.chan));
    if (out_mon.out_note_number !== want.note)
      report($sformatf("out_note_number got %0d want %0d", out_mon.out_note_number, want.note));
    if (out_mon.out_velocity !== want.vel)
      report($sformatf("out_velocity got %0d want %0d", out_mon.out_velocity, want.vel));
    if (out_mon.last !== want.last)
      report($sformatf("last got %0b want %0b", out_mon.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      send_enable = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) held[i] = 1'b0;
      expected_notes.delete();
    end else begin
      if (cfg_wr_en) send_enable = cfg_wr_data;
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) begin
        track_event(in_mon.func, in_mon.is_note_off, in_mon.channel, in_mon.note_number,
                    in_mon.original_note, in_mon.velocity);
      end
    end
    outstanding <= expected_notes.size();
  end

endmodule

// ===== sim/note_remap_tracker_tb.sv =====
`timescale 1ns / 1ps

module note_remap_tracker_tb;
  import nrt_pkg::*;
  import nrt_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int FLOOD_NOTES   = 40;

  logic clk       = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic rx_ready  = 1'b0;
  logic hold_kick = 1'b0;

  int fail_count, outstanding, results_seen, drops, widest_release;
  int cycle_count;
  int n_on, n_off, n_pending;
  int burst_left;

  nrt_in_if  in_if ();
  nrt_out_if out_if ();

  assign out_if.ready = rx_ready;

  note_remap_tracker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  note_remap_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .drops          (drops),
    .widest_release (widest_release)
  );

  always #2 clk = ~clk;

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: stall pattern changes after a random span; a toggle of
  // hold_kick starts a long hold-off counted here.
  initial begin : receiver
    int   mode;
    int   span;
    int   hold_left;
    logic seen;
    mode      = 0;
    span      = 0;
    hold_left = 0;
    seen      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_kick != seen) begin
        seen      = hold_kick;
        hold_left = HOLD_CYCLES;
      end
      if (span == 0) begin
        mode = int'($urandom_range(0, 3));
        span = int'($urandom_range(20, 120));
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        rx_ready <= 1'b0;
      end else begin
        case (mode)
          0: rx_ready <= 1'b1;
          1: rx_ready <= 1'($urandom_range(0, 1));
          2: rx_ready <= ($urandom_range(0, 3) == 0);
          default: rx_ready <= ((span % 8) < 5);
        endcase
      end
    end
  end

  function automatic chan_t pick_chan();
    if ($urandom_range(0, 3) == 0) return chan_t'($urandom_range(0, 16));
    return chan_t'($urandom_range(0, 3));
  endfunction

  function automatic note_t pick_note();
    if ($urandom_range(0, 3) == 0) return note_t'($urandom_range(0, 127));
    return note_t'($urandom_range(60, 67));
  endfunction

  // Offer one item, hold it until the transfer, then maybe open a gap.
  task automatic push_item(input logic func, input logic is_off, input chan_t ch,
                           input note_t note, input note_t orig, input vel_t vel);
    int gap;
    in_if.valid         <= 1'b1;
    in_if.func          <= func;
    in_if.is_note_off   <= is_off;
    in_if.channel       <= ch;
    in_if.note_number   <= note;
    in_if.original_note <= orig;
    in_if.velocity      <= vel;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (func == FUNC_PENDING_OFF) n_pending++;
    else if (is_off == MSG_NOTE_OFF) n_off++;
    else n_on++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(15, 40))
                                               : int'($urandom_range(1, 6));
      gap = int'($urandom_range(0, 6));
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid, wait for every queued result, then let the block go idle.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly chords (one original note fanned out to several mapped notes) and
  // their note-offs on a small key pool, plus pending-offs and raw noise.
  task automatic random_mix(input int count);
    int    done;
    int    r;
    int    k;
    chan_t ch;
    note_t orig;
    done = 0;
    while (done < count) begin
      r    = int'($urandom_range(0, 99));
      ch   = pick_chan();
      orig = pick_note();
      if (r < 35) begin
        k = int'($urandom_range(1, 3));
        repeat (k) begin
          push_item(FUNC_NOTE, MSG_NOTE_ON, ch, note_t'(orig + $urandom_range(0, 12)), orig,
                    vel_t'($urandom_range(0, 127)));
        end
        done += k;
      end else if (r < 80) begin
        push_item(FUNC_NOTE, MSG_NOTE_OFF, ch, note_t'($urandom_range(0, 127)), orig,
                  vel_t'($urandom_range(0, 127)));
        done++;
      end else if (r < 90) begin
        push_item(FUNC_PENDING_OFF, 1'($urandom_range(0, 1)), ch,
                  note_t'(orig + $urandom_range(0, 12)), note_t'($urandom_range(0, 127)),
                  vel_t'($urandom_range(0, 127)));
        done++;
      end else begin
        push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  chan_t'($urandom_range(0, 16)), note_t'($urandom_range(0, 127)),
                  note_t'($urandom_range(0, 127)), vel_t'($urandom_range(0, 127)));
        done++;
      end
    end
  endtask

  initial begin : stimulus
    in_if.valid         <= 1'b0;
    in_if.func          <= FUNC_NOTE;
    in_if.is_note_off   <= MSG_NOTE_ON;
    in_if.channel       <= '0;
    in_if.note_number   <= '0;
    in_if.original_note <= '0;
    in_if.velocity      <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= 1'b0;
    rst_n               <= 1'b0;
    n_on       = 0;
    n_off      = 0;
    n_pending  = 0;
    burst_left = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_enable(1'b1);
    // field extremes, release of a single note, releases with no match
    push_item(FUNC_NOTE, MSG_NOTE_ON, 5'd0, 7'd0, 7'd0, 7'd0);
    push_item(FUNC_NOTE, MSG_NOTE_ON, 5'd16, 7'd127, 7'd127, 7'd127);
    push_item(FUNC_NOTE, MSG_NOTE_OFF, 5'd16, 7'd0, 7'd127, 7'd127);
    push_item(FUNC_NOTE, MSG_NOTE_OFF, 5'd16, 7'd127, 7'd127, 7'd1);
    push_item(FUNC_PENDING_OFF, MSG_NOTE_OFF, 5'd0, 7'd0, 7'd127, 7'd127);
    push_item(FUNC_NOTE, MSG_NOTE_OFF, 5'd0, 7'd0, 7'd0, 7'd0);
    // chord on one original note, drop one voice, release the rest
    push_item(FUNC_NOTE, MSG_NOTE_ON, 5'd9, 7'd64, 7'd64, 7'd100);
    push_item(FUNC_NOTE, MSG_NOTE_ON, 5'd9, 7'd67, 7'd64, 7'd101);
    push_item(FUNC_NOTE, MSG_NOTE_ON, 5'd9, 7'd71, 7'd64, 7'd102);
    push_item(FUNC_PENDING_OFF, MSG_NOTE_ON, 5'd9, 7'd67, 7'd0, 7'd0);
    push_item(FUNC_NOTE, MSG_NOTE_OFF, 5'd9, 7'd1, 7'd64, 7'd0);
    // wrong channel, and original vs mapped note confusion
    push_item(FUNC_NOTE, MSG_NOTE_ON, 5'd5, 7'd10, 7'd117, 7'd33);
    push_item(FUNC_NOTE, MSG_NOTE_OFF, 5'd4, 7'd10, 7'd117, 7'd33);
    push_item(FUNC_PENDING_OFF, MSG_NOTE_ON, 5'd5, 7'd117, 7'd10, 7'd33);
    push_item(FUNC_NOTE, MSG_NOTE_OFF, 5'd5, 7'd117, 7'd10, 7'd33);
    push_item(FUNC_NOTE, MSG_NOTE_OFF, 5'd5, 7'd0, 7'd117, 7'd85);
    push_item(FUNC_NOTE, MSG_NOTE_ON, 5'd15, 7'd85, 7'd42, 7'd42);
    push_item(FUNC_NOTE, MSG_NOTE_OFF, 5'd15, 7'd85, 7'd42, 7'd42);
    settle();

    // Table is empty now: overfill it on one key, then release all of it at once
    // while the result side holds off and the sender keeps offering items.
    repeat (FLOOD_NOTES) begin
      push_item(FUNC_NOTE, MSG_NOTE_ON, 5'd7, note_t'($urandom_range(0, 127)), 7'd33,
                vel_t'($urandom_range(0, 127)));
    end
    hold_kick <= ~hold_kick;
    push_item(FUNC_NOTE, MSG_NOTE_OFF, 5'd7, 7'd0, 7'd33, 7'd99);
    random_mix(120);
    settle();

    write_enable(1'b0);
    random_mix(90);
    settle();

    write_enable(1'b1);
    random_mix(130);
    settle();

    write_enable(1'b0);
    random_mix(30);
    settle();

    write_enable(1'b1);
    random_mix(60);
    settle();

    $display("Sent %0d note-ons, %0d note-offs and %0d pending-offs, output on and off.",
             n_on, n_off, n_pending);
    $display("Checked %0d results; %0d note-ons found the table full; widest release %0d.",
             results_seen, drops, widest_release);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, outstanding);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
